// File: rtl/core/xor_checked_frame_checker_defines.svh
// Assertion macros for the frame checker modules.
`ifndef XOR_CHECKED_FRAME_CHECKER_DEFINES_SVH
`define XOR_CHECKED_FRAME_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/xcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcfc_pkg;

	localparam logic [7:0] HEADER_BYTE  = 8'hAF;
	localparam logic [7:0] TRAILER_BYTE = 8'h3C;

	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_FIRST_ID = 4'd1;
	localparam logic [POS_W-1:0] POS_LAST_ID  = 4'd8;
	localparam logic [POS_W-1:0] POS_TYPE     = 4'd9;
	localparam logic [POS_W-1:0] POS_SAT      = 4'd10;

	typedef enum logic [1:0] {
		ST_VALID       = 2'd0,
		ST_BAD_HEADER  = 2'd1,
		ST_ID_MISMATCH = 2'd2,
		ST_NO_TRAILER  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] frame_type;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/xcfc_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module xcfc_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire xcfc_pkg::in_item_t in_item,
	output logic                   in_stall,
	input  wire logic              advance,
	output logic                   fire,
	output xcfc_pkg::in_item_t     item_s1
);
	import xcfc_pkg::*;

	logic valid_s1;
	logic load;

	// The stage holds its request only while the result side cannot take it.
	assign fire     = valid_s1 & advance;
	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/xcfc_frame_logic.sv
`timescale 1ns / 1ps
`default_nettype none

`include "xor_checked_frame_checker_defines.svh"

module xcfc_frame_logic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [63:0]        station_id,
	input  wire logic               fire,
	input  wire xcfc_pkg::in_item_t item_s1,
	output logic                    res_valid,
	output xcfc_pkg::result_t       res
);
	import xcfc_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	logic [7:0]       prev_q;
	logic [7:0]       type_q;
	logic             decided_q;

	logic [7:0] b;
	logic [2:0] id_idx;
	logic [2:0] lane;
	logic [7:0] want;
	logic [7:0] cur_type;
	logic       hit;
	status_t    hit_status;

	assign b = item_s1.rx_byte;

	// Position 1 checks the top byte of the identifier, position 8 the bottom one.
	assign id_idx = 3'(pos_q - POS_FIRST_ID);
	assign lane   = 3'd7 - id_idx;
	assign want   = station_id[{lane, 3'b000} +: 8];

	assign cur_type = (pos_q == POS_TYPE) ? b : type_q;

	always_comb begin
		hit        = 1'b0;
		hit_status = ST_VALID;
		if (pos_q == '0) begin
			if (b != HEADER_BYTE) begin
				hit        = 1'b1;
				hit_status = ST_BAD_HEADER;
			end
		end else if (pos_q inside {[POS_FIRST_ID:POS_LAST_ID]}) begin
			if (b != want) begin
				hit        = 1'b1;
				hit_status = ST_ID_MISMATCH;
			end
		end else begin
			if (b == TRAILER_BYTE && prev_q == xor_q) begin
				hit        = 1'b1;
				hit_status = ST_VALID;
			end
		end
	end

	always_comb begin
		res_valid      = 1'b0;
		res.status     = ST_VALID;
		res.frame_type = 8'h00;
		if (fire && !decided_q) begin
			if (hit) begin
				res_valid      = 1'b1;
				res.status     = hit_status;
				res.frame_type = (hit_status == ST_VALID) ? cur_type : 8'h00;
			end else if (item_s1.frame_end) begin
				res_valid  = 1'b1;
				res.status = ST_NO_TRAILER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= 8'h00;
			prev_q    <= 8'h00;
			type_q    <= 8'h00;
			decided_q <= 1'b0;
		end else if (fire) begin
			if (item_s1.frame_end) begin
				pos_q     <= '0;
				xor_q     <= 8'h00;
				prev_q    <= 8'h00;
				type_q    <= 8'h00;
				decided_q <= 1'b0;
			end else if (!decided_q) begin
				if (res_valid) begin
					decided_q <= 1'b1;
				end
				if (pos_q == POS_TYPE) begin
					type_q <= b;
				end
				// The running XOR lags two bytes behind the current one.
				if (pos_q >= 4'd2) begin
					xor_q <= xor_q ^ prev_q;
				end
				prev_q <= b;
				if (pos_q < POS_SAT) begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

	`XCFC_ASSERT_SAME(a_no_result_after_decision, clk, arst_n, fire && decided_q, !res_valid, "result after frame already decided")
	`XCFC_ASSERT_SAME(a_result_only_on_fire, clk, arst_n, res_valid, fire, "result without a byte in progress")
	`XCFC_ASSERT_SAME(a_valid_needs_trailer, clk, arst_n, res_valid && res.status == ST_VALID, b == TRAILER_BYTE && pos_q >= POS_TYPE, "valid frame without trailer byte")
	`XCFC_ASSERT_NEXT(a_frame_end_clears, clk, arst_n, fire && item_s1.frame_end, pos_q == '0 && !decided_q && xor_q == 8'h00, "frame state not cleared after frame end")

endmodule

`default_nettype wire

// File: rtl/core/xcfc_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module xcfc_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire xcfc_pkg::result_t res,
	output logic                   advance,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output xcfc_pkg::result_t      out_res
);
	import xcfc_pkg::*;

	logic    out_valid_q;
	result_t res_q;

	// A new result may enter when the register is empty or is being drained.
	assign advance   = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/xor_checked_frame_checker.sv
// Frame checker: takes one received byte per request and returns one status per frame.
// Byte 0 must be 0xAF, bytes 1 to 8 must match station_id (top byte first), byte 9 is
// the frame type, and from position 9 on a 0x3C byte whose predecessor equals the XOR
// of bytes 1 to i-2 ends the frame as valid. The result appears at the first decision;
// the remaining bytes up to frame_end are consumed without a result, and frame_end
// always starts a fresh frame. A byte passes through an input register and a result
// register, and its result is presented from the result register. One byte is
// accepted every cycle unless the result register holds a result that the output
// side is stalling. Write station_id only while no frame is in progress.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [63:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       frame_type
);
	import xcfc_pkg::*;

	logic [63:0] station_id_q;
	in_item_t    in_item;
	in_item_t    item_s1;
	logic        advance;
	logic        fire;
	logic        res_valid;
	result_t     res;
	result_t     out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_id_q <= 64'h0;
		end else if (cfg_wr_en) begin
			station_id_q <= cfg_wr_data;
		end
	end

	assign in_item.rx_byte   = rx_byte;
	assign in_item.frame_end = frame_end;

	xcfc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.in_stall (in_stall),
		.advance  (advance),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	xcfc_frame_logic u_frame_logic (
		.clk        (clk),
		.arst_n     (arst_n),
		.station_id (station_id_q),
		.fire       (fire),
		.item_s1    (item_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	xcfc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign status     = out_res.status;
	assign frame_type = out_res.frame_type;

endmodule

`default_nettype wire
